/* rtl/ipv4hc_pkg.sv */
`default_nettype none
package ipv4hc_pkg;

	typedef enum logic [2:0] {
		VERDICT_ACCEPT   = 3'd0,
		VERDICT_VERSION  = 3'd1,
		VERDICT_LENGTH   = 3'd2,
		VERDICT_TTL_ZERO = 3'd3,
		VERDICT_DEST     = 3'd4,
		VERDICT_CHECKSUM = 3'd5
	} verdict_t;

	localparam logic [3:0]  IP_VERSION     = 4'd4;
	localparam logic [3:0]  MIN_IHL        = 4'd5;
	localparam logic [5:0]  TTL_POS        = 6'd8;
	localparam logic [5:0]  DEST_FIRST_POS = 6'd16;
	localparam logic [5:0]  DEST_LAST_POS  = 6'd19;
	localparam logic [7:0]  BCAST_BYTE     = 8'hff;
	localparam logic [15:0] SUM_GOOD       = 16'hffff;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [5:0] header_bytes;
	} out_item_t;

	// per-byte outcome from the core
	typedef struct packed {
		logic      produce;
		out_item_t item;
	} core_res_t;

endpackage
`default_nettype wire

/* rtl/ipv4hc_core.sv */
`default_nettype none
module ipv4hc_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire ipv4hc_pkg::in_item_t item,
	input  wire                   fire,
	input  wire            [31:0] local_address,
	output ipv4hc_pkg::core_res_t res
);
	import ipv4hc_pkg::*;

	logic [5:0]  byte_position_q, byte_position_nxt;
	logic [3:0]  header_words_q, header_words_nxt;
	logic [15:0] running_sum_q, running_sum_nxt;
	logic [7:0]  pending_high_byte_q, pending_high_byte_nxt;
	logic        ttl_zero_seen_q, ttl_zero_seen_nxt;
	logic        not_local_seen_q, not_local_seen_nxt;
	logic        not_broadcast_seen_q, not_broadcast_seen_nxt;
	logic        waiting_for_start_q, waiting_for_start_nxt;

	logic [3:0]  ver;
	logic [3:0]  ihl;
	logic [5:0]  last_pos;
	logic [16:0] sum_wide;
	logic [15:0] sum_fold;
	logic [7:0]  local_byte;

	always_comb begin
		ver        = item.data_byte[7:4];
		ihl        = item.data_byte[3:0];
		last_pos   = {header_words_q, 2'b00} - 6'd1;
		sum_wide   = {1'b0, running_sum_q} + {1'b0, pending_high_byte_q, item.data_byte};
		// end-around carry
		sum_fold   = sum_wide[15:0] + {15'd0, sum_wide[16]};
		unique case (byte_position_q[1:0])
			2'd0:    local_byte = local_address[31:24];
			2'd1:    local_byte = local_address[23:16];
			2'd2:    local_byte = local_address[15:8];
			default: local_byte = local_address[7:0];
		endcase

		byte_position_nxt      = byte_position_q;
		header_words_nxt       = header_words_q;
		running_sum_nxt        = running_sum_q;
		pending_high_byte_nxt  = pending_high_byte_q;
		ttl_zero_seen_nxt      = ttl_zero_seen_q;
		not_local_seen_nxt     = not_local_seen_q;
		not_broadcast_seen_nxt = not_broadcast_seen_q;
		waiting_for_start_nxt  = waiting_for_start_q;
		res                    = '0;

		if (item.first_byte) begin
			if (ver != IP_VERSION) begin
				res.produce           = 1'b1;
				res.item.verdict      = VERDICT_VERSION;
				res.item.header_bytes = (ihl >= MIN_IHL) ? {ihl, 2'b00} : 6'd0;
				waiting_for_start_nxt = 1'b1;
			end else if (ihl < MIN_IHL) begin
				res.produce           = 1'b1;
				res.item.verdict      = VERDICT_LENGTH;
				res.item.header_bytes = 6'd0;
				waiting_for_start_nxt = 1'b1;
			end else begin
				header_words_nxt       = ihl;
				running_sum_nxt        = '0;
				pending_high_byte_nxt  = item.data_byte;
				ttl_zero_seen_nxt      = 1'b0;
				not_local_seen_nxt     = 1'b0;
				not_broadcast_seen_nxt = 1'b0;
				byte_position_nxt      = 6'd1;
				waiting_for_start_nxt  = 1'b0;
			end
		end else if (!waiting_for_start_q) begin
			if (!byte_position_q[0])
				pending_high_byte_nxt = item.data_byte;
			else
				running_sum_nxt = sum_fold;

			if (byte_position_q == TTL_POS && item.data_byte == 8'd0)
				ttl_zero_seen_nxt = 1'b1;

			if (byte_position_q >= DEST_FIRST_POS && byte_position_q <= DEST_LAST_POS) begin
				if (item.data_byte != local_byte)
					not_local_seen_nxt = 1'b1;
				if (item.data_byte != BCAST_BYTE)
					not_broadcast_seen_nxt = 1'b1;
			end

			if (byte_position_q >= last_pos) begin
				res.produce           = 1'b1;
				res.item.header_bytes = {header_words_q, 2'b00};
				waiting_for_start_nxt = 1'b1;
				priority if (ttl_zero_seen_nxt)
					res.item.verdict = VERDICT_TTL_ZERO;
				else if (not_local_seen_nxt && not_broadcast_seen_nxt)
					res.item.verdict = VERDICT_DEST;
				else if (running_sum_nxt != SUM_GOOD)
					res.item.verdict = VERDICT_CHECKSUM;
				else
					res.item.verdict = VERDICT_ACCEPT;
			end else begin
				byte_position_nxt = byte_position_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q      <= '0;
			header_words_q       <= '0;
			running_sum_q        <= '0;
			pending_high_byte_q  <= '0;
			ttl_zero_seen_q      <= 1'b0;
			not_local_seen_q     <= 1'b0;
			not_broadcast_seen_q <= 1'b0;
			waiting_for_start_q  <= 1'b1;
		end else if (fire) begin
			byte_position_q      <= byte_position_nxt;
			header_words_q       <= header_words_nxt;
			running_sum_q        <= running_sum_nxt;
			pending_high_byte_q  <= pending_high_byte_nxt;
			ttl_zero_seen_q      <= ttl_zero_seen_nxt;
			not_local_seen_q     <= not_local_seen_nxt;
			not_broadcast_seen_q <= not_broadcast_seen_nxt;
			waiting_for_start_q  <= waiting_for_start_nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/ipv4_header_checker.sv */
// Path: input register, then core, then the registered verdict shown on out_valid.
// Throughput: one header byte per cycle; the input register moves on while a verdict
//   waits in the output register, and stalls only when a new verdict would collide with it.
// Reset: arst_n clears all control state and local_address; the checker then ignores
//   bytes until one arrives with first_byte set.
`default_nettype none
module ipv4_header_checker (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire ipv4hc_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output ipv4hc_pkg::out_item_t  out_data,
	input  wire                    cfg_wr_en,
	input  wire             [31:0] cfg_wr_data
);
	import ipv4hc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic [31:0] local_address_q;
	logic      out_valid_q;
	out_item_t out_item_q;
	core_res_t res;
	logic      advance;

	ipv4hc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_s1),
		.fire          (advance),
		.local_address (local_address_q),
		.res           (res)
	);

	// a byte with no verdict never waits on the output side
	assign advance  = valid_s1 && (!res.produce || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			local_address_q <= '0;
		end else begin
			if (cfg_wr_en)
				local_address_q <= cfg_wr_data;
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance && res.produce)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
		if (advance && res.produce)
			out_item_q <= res.item;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule
`default_nettype wire

/* rtl/ipv4hc_checker.sv */
`default_nettype none
module ipv4hc_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   out_valid,
	input wire                   out_ready,
	input wire ipv4hc_pkg::out_item_t out_data
);
	import ipv4hc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("verdict dropped or changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.verdict <= VERDICT_CHECKSUM)
		else $error("verdict code out of range");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.verdict == VERDICT_LENGTH |-> out_data.header_bytes == 6'd0)
		else $error("length error with nonzero header size");

	a_full_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.verdict != VERDICT_LENGTH && out_data.verdict != VERDICT_VERSION
		|-> out_data.header_bytes >= 6'd20 && out_data.header_bytes[1:0] == 2'b00)
		else $error("full-header verdict with bad header size");

endmodule

bind ipv4_header_checker ipv4hc_checker u_ipv4hc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

/* dv/ipv4_header_checker_test.sv */
`timescale 1ns / 100ps
`default_nettype none
module ipv4_header_checker_test;
	import ipv4hc_pkg::*;

	localparam int ITEM_GOAL = 850;
	localparam int PHASES = 5;
	localparam int LONG_HOLD = 80;
	localparam int SETTLE_CYCLES = 6;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLUGGISH} rx_mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       gives;
		verdict_t   verdict;
		logic [5:0] header_bytes;
	} plan_row_t;

	// single-byte cases whose outcome is plain from the header rules
	localparam plan_row_t PLAN [18] = '{
		'{8'h00, 1'b0, 1'b0, VERDICT_ACCEPT,   6'd0},  // idle after reset
		'{8'hff, 1'b0, 1'b0, VERDICT_ACCEPT,   6'd0},
		'{8'h00, 1'b1, 1'b1, VERDICT_VERSION,  6'd0},
		'{8'hff, 1'b1, 1'b1, VERDICT_VERSION,  6'd60},
		'{8'h55, 1'b1, 1'b1, VERDICT_VERSION,  6'd20},
		'{8'h40, 1'b1, 1'b1, VERDICT_LENGTH,   6'd0},
		'{8'h44, 1'b1, 1'b1, VERDICT_LENGTH,   6'd0},
		'{8'h7e, 1'b0, 1'b0, VERDICT_ACCEPT,   6'd0},  // ignored after a verdict
		'{8'h45, 1'b1, 1'b0, VERDICT_ACCEPT,   6'd0},
		'{8'hab, 1'b0, 1'b0, VERDICT_ACCEPT,   6'd0},
		'{8'h00, 1'b0, 1'b0, VERDICT_ACCEPT,   6'd0},
		'{8'h3f, 1'b1, 1'b1, VERDICT_VERSION,  6'd60}, // restart into a bad version
		'{8'h4f, 1'b1, 1'b0, VERDICT_ACCEPT,   6'd0},
		'{8'hff, 1'b0, 1'b0, VERDICT_ACCEPT,   6'd0},
		'{8'h41, 1'b1, 1'b1, VERDICT_LENGTH,   6'd0},  // restart into a bad length
		'{8'hf4, 1'b1, 1'b1, VERDICT_VERSION,  6'd0},
		'{8'h81, 1'b0, 1'b0, VERDICT_ACCEPT,   6'd0},
		'{8'h46, 1'b1, 1'b0, VERDICT_ACCEPT,   6'd0}   // dropped by the next header
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	ipv4_header_checker dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// header state as the checker should hold it
	logic [31:0] shadow_local = '0;
	logic [5:0]  hdr_pos = '0;
	logic [3:0]  hdr_words = '0;
	logic [15:0] hdr_sum = '0;
	logic [7:0]  hdr_high = '0;
	logic        saw_ttl_zero = 1'b0;
	logic        saw_not_local = 1'b0;
	logic        saw_not_bcast = 1'b0;
	logic        hdr_idle = 1'b1;

	out_item_t   pending_verdicts [$];
	out_item_t   oldest;
	logic [7:0]  hdr_bytes [60];
	int          errors = 0;
	int          bytes_used = 0;
	int          verdict_hits [6] = '{default: 0};
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	rx_mode_t    rx_mode = RX_RANDOM;
	int          hold_ticket = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          rx_phase = 0;

	function automatic logic [15:0] add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = a + b;
		return s[15:0] + 16'(s[16]);
	endfunction

	task automatic predict_verdict(input logic [7:0] b, input logic f,
			output logic got, output out_item_t res);
		logic [5:0] last;
		got = 1'b0;
		res = '0;
		if (f) begin
			bytes_used++;
			if (b[7:4] != IP_VERSION) begin
				got = 1'b1;
				res.verdict = VERDICT_VERSION;
				res.header_bytes = (b[3:0] >= MIN_IHL) ? {b[3:0], 2'b00} : 6'd0;
				hdr_idle = 1'b1;
			end else if (b[3:0] < MIN_IHL) begin
				got = 1'b1;
				res.verdict = VERDICT_LENGTH;
				res.header_bytes = 6'd0;
				hdr_idle = 1'b1;
			end else begin
				hdr_words = b[3:0];
				hdr_sum = '0;
				hdr_high = b;
				saw_ttl_zero = 1'b0;
				saw_not_local = 1'b0;
				saw_not_bcast = 1'b0;
				hdr_pos = 6'd1;
				hdr_idle = 1'b0;
			end
		end else if (!hdr_idle) begin
			bytes_used++;
			if (hdr_pos[0])
				hdr_sum = add16(hdr_sum, {hdr_high, b});
			else
				hdr_high = b;
			if (hdr_pos == TTL_POS && b == 8'h00)
				saw_ttl_zero = 1'b1;
			if (hdr_pos >= DEST_FIRST_POS && hdr_pos <= DEST_LAST_POS) begin
				// compared against the address in force when this byte lands
				if (b != shadow_local[8 * (DEST_LAST_POS - hdr_pos) +: 8])
					saw_not_local = 1'b1;
				if (b != BCAST_BYTE)
					saw_not_bcast = 1'b1;
			end
			last = {hdr_words, 2'b00} - 6'd1;
			if (hdr_pos >= last) begin
				got = 1'b1;
				if (saw_ttl_zero)
					res.verdict = VERDICT_TTL_ZERO;
				else if (saw_not_local && saw_not_bcast)
					res.verdict = VERDICT_DEST;
				else if (hdr_sum != SUM_GOOD)
					res.verdict = VERDICT_CHECKSUM;
				else
					res.verdict = VERDICT_ACCEPT;
				res.header_bytes = {hdr_words, 2'b00};
				hdr_idle = 1'b1;
			end else begin
				hdr_pos = hdr_pos + 6'd1;
			end
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic f,
			output logic got, output out_item_t res);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, first_byte: f};
		do @(posedge clk); while (!in_ready);
		predict_verdict(b, f, got, res);
		if (got)
			pending_verdicts.push_back(res);
	endtask

	// stop sending and let the checker drain completely
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_local(input logic [31:0] addr);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= addr;
		@(posedge clk) shadow_local = addr;
		@(negedge clk) cfg_wr_en <= 1'b0;
	endtask

	function automatic void build_header(input logic [3:0] ihl, input bit ttl0,
			input logic [31:0] dst, input bit bad_sum);
		logic [15:0] total;
		logic [15:0] sum_field;
		total = '0;
		for (int i = 0; i < 60; i++) hdr_bytes[i] = 8'($urandom);
		hdr_bytes[0] = {IP_VERSION, ihl};
		hdr_bytes[8] = ttl0 ? 8'h00 : 8'($urandom_range(1, 255));
		hdr_bytes[10] = 8'h00;
		hdr_bytes[11] = 8'h00;
		for (int j = 0; j < 4; j++) hdr_bytes[16 + j] = dst[8 * (3 - j) +: 8];
		for (int i = 0; i < 2 * ihl; i++)
			total = add16(total, {hdr_bytes[2 * i], hdr_bytes[2 * i + 1]});
		sum_field = ~total;
		if (bad_sum)
			sum_field ^= 16'(1) << $urandom_range(0, 15);
		{hdr_bytes[10], hdr_bytes[11]} = sum_field;
	endfunction

	// receiver: own stall pattern, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_ticket) begin
			hold_seen = hold_ticket;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: begin
					rx_phase = (rx_phase + 1) % 5;
					out_ready <= (rx_phase < 2);
				end
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict %0d / %0d bytes with nothing outstanding",
					out_data.verdict, out_data.header_bytes);
				errors++;
			end else begin
				oldest = pending_verdicts.pop_front();
				verdict_hits[int'(oldest.verdict)]++;
				if (out_data.verdict !== oldest.verdict) begin
					$error("verdict: expected %0d, got %0d", oldest.verdict, out_data.verdict);
					errors++;
				end
				if (out_data.header_bytes !== oldest.header_bytes) begin
					$error("header_bytes: expected %0d, got %0d",
						oldest.header_bytes, out_data.header_bytes);
					errors++;
				end
			end
		end
	end

	initial begin
		logic        got;
		out_item_t   res;
		logic [3:0]  ihl;
		logic [31:0] dst;
		logic [31:0] addr;
		logic [7:0]  b;
		bit          ttl0;
		bit          bad_sum;
		int          pick;
		int          cut;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			push_byte(PLAN[i].data_byte, PLAN[i].first_byte, got, res);
			if (got !== PLAN[i].gives ||
					(got && res !== {PLAN[i].verdict, PLAN[i].header_bytes})) begin
				$error("request %0d: table says %0d/%0d/%0d, predictor %0d/%0d/%0d", i,
					PLAN[i].gives, PLAN[i].verdict, PLAN[i].header_bytes,
					got, res.verdict, res.header_bytes);
				errors++;
			end
		end

		// address changes between the two halves of the destination
		settle();
		write_local(32'hc0a8_0a01);
		build_header(4'd5, 1'b0, 32'hc0a8_0203, 1'b0);
		for (int i = 0; i < 18; i++) push_byte(hdr_bytes[i], i == 0, got, res);
		settle();
		write_local(32'h0a00_0203);
		for (int i = 18; i < 20; i++) push_byte(hdr_bytes[i], 1'b0, got, res);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: addr = 32'h0000_0000;
				1: addr = 32'hffff_ffff;
				3: addr = 32'h8000_0001;
				default: addr = $urandom;
			endcase
			write_local(addr);
			gaps_on = (ph != 2);
			case (ph)
				0: rx_mode = RX_RANDOM;
				3: rx_mode = RX_PATTERN;
				4: rx_mode = RX_SLUGGISH;
				default: rx_mode = RX_ALWAYS;
			endcase
			if (ph == 1) begin
				// receiver holds off while bad first bytes keep coming
				hold_ticket++;
				repeat (30) begin
					b = 8'($urandom);
					if (b[7:4] == IP_VERSION)
						b[7:4] = 4'h6;
					push_byte(b, 1'b1, got, res);
				end
			end
			while (bytes_used < ITEM_GOAL * (ph + 1) / PHASES) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					ihl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(7, 15))
						: 4'($urandom_range(5, 6));
					ttl0 = ($urandom_range(0, 9) == 0);
					bad_sum = ($urandom_range(0, 5) == 0);
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: dst = shadow_local;
						5, 6: dst = 32'hffff_ffff;
						7: dst = shadow_local ^ (32'd1 << $urandom_range(0, 31));
						default: dst = $urandom;
					endcase
					build_header(ihl, ttl0, dst, bad_sum);
					cut = int'({ihl, 2'b00});
					if (pick >= 70)
						cut = $urandom_range(1, cut - 1);  // broken off, next header restarts
					for (int i = 0; i < cut; i++) push_byte(hdr_bytes[i], i == 0, got, res);
				end else if (pick < 90) begin
					repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, got, res);
				end else begin
					push_byte(8'($urandom), 1'b1, got, res);
				end
			end
		end

		settle();
		$display("Ran %0d header bytes through %0d address settings, one mid-header.",
			bytes_used, PHASES + 2);
		$display("Verdicts: accept %0d, version %0d, length %0d, ttl %0d, dest %0d, sum %0d",
			verdict_hits[0], verdict_hits[1], verdict_hits[2],
			verdict_hits[3], verdict_hits[4], verdict_hits[5]);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
rtl/ipv4hc_pkg.sv
rtl/ipv4hc_core.sv
rtl/ipv4_header_checker.sv
rtl/ipv4hc_checker.sv
dv/ipv4_header_checker_test.sv
